@@ rtl/intrusion_alarm_controller_defines.svh @@
// Assertion macros for the intrusion alarm controller checker.
// No dependencies; included by files that assert.
`ifndef INTRUSION_ALARM_CONTROLLER_DEFINES_SVH
`define INTRUSION_ALARM_CONTROLLER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define IAC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("alarm controller check failed");

// next-cycle implication
`define IAC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("alarm controller check failed");

`endif

@@ rtl/iac_pkg.sv @@
// Shared types and constants of the intrusion alarm controller.
// No dependencies.
`timescale 1ns / 1ps

package iac_pkg;

	typedef enum logic [1:0] {
		MODE_DISARMED = 2'd0,
		MODE_EXIT     = 2'd1,
		MODE_ARMED    = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KEY_NONE    = 2'd0,
		KEY_VALID   = 2'd1,
		KEY_INVALID = 2'd2
	} key_res_t;

	typedef struct packed {
		logic        key_present;
		logic [31:0] key_value;
		logic [7:0]  zone_levels;
		logic        host_arm_write;
		logic        host_arm_value;
	} in_word_t;

	typedef struct packed {
		mode_t    alarm_state;
		logic     siren_drive;
		logic     siren_active;
		logic     arm_flag_out;
		key_res_t key_result;
		logic     zone_tripped;
	} out_word_t;

	typedef struct packed {
		logic [15:0] armed_delay_ticks;
		logic [15:0] siren_ticks;
		logic [15:0] beep_on_ticks;
		logic [15:0] beep_off_ticks;
		logic [7:0]  zone_enable_mask;
		logic        siren_muted;
		logic [31:0] key_a;
		logic [31:0] key_b;
	} cfg_t;

	localparam int unsigned ADDR_W = 5;

	localparam logic [2:0] REG_ARMED_DELAY = 3'd0;
	localparam logic [2:0] REG_SIREN_TICKS = 3'd1;
	localparam logic [2:0] REG_BEEP_ON     = 3'd2;
	localparam logic [2:0] REG_BEEP_OFF    = 3'd3;
	localparam logic [2:0] REG_ZONE_MASK   = 3'd4;
	localparam logic [2:0] REG_MUTED       = 3'd5;
	localparam logic [2:0] REG_KEY_A       = 3'd6;
	localparam logic [2:0] REG_KEY_B       = 3'd7;

	localparam logic [15:0] RST_ARMED_DELAY = 16'd300;
	localparam logic [15:0] RST_SIREN_TICKS = 16'd1800;
	localparam logic [15:0] RST_BEEP_ON     = 16'd5;
	localparam logic [15:0] RST_BEEP_OFF    = 16'd10;

endpackage

@@ rtl/intrusion_alarm_controller.sv @@
// Top level of the intrusion alarm controller: input register, core, result register.
// Depends on iac_pkg, iac_regs, iac_core.
`timescale 1ns / 1ps

//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+-------------------------------
//  in      | in        | in_valid / in_ready     | in_word_t: one scheduler tick
//  out     | out       | out_valid / out_ready   | out_word_t: state after the tick
//  apb     | in        | psel, penable / pready  | pwdata, prdata (paddr 4*index)
//
// One word per cycle sustained while out_ready stays high; a word taken into the input
// register moves into the result register when that register is free, so out_valid
// rises once the word has moved. The whole tick update is a single combinational pass
// through the core between those two registers, so nothing iterates.
// Stalls: out_ready low holds the result; in_ready drops only when both the
// input register and the result register are full and out_ready is low.
// Reset (arst_n low): disarmed, all timers zero, siren low, registers at defaults.

module intrusion_alarm_controller import iac_pkg::*; #(
	parameter int unsigned NUM_ZONES  = 8,
	parameter int unsigned NUM_KEYS   = 2,
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_word_t          in_word,
	output logic              out_valid,
	input  logic              out_ready,
	output out_word_t         out_word,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t      cfg;
	in_word_t  item_s1;
	logic      valid_s1;
	out_word_t res;
	out_word_t res_s2;
	logic      valid_s2;
	logic      step;
	logic      out_free;

	// result register can take a word when empty or being drained
	assign out_free = !valid_s2 || out_ready;
	// the tick in the input register is applied to the state when it moves on
	assign step     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) valid_s1 <= 1'b1;
			else if (step)            valid_s1 <= 1'b0;
			if (step)                 valid_s2 <= 1'b1;
			else if (out_ready)       valid_s2 <= 1'b0;
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_s1 <= in_word;
		if (step)                 res_s2  <= res;
	end

	iac_regs #(
		.NUM_ZONES (NUM_ZONES),
		.NUM_KEYS  (NUM_KEYS)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	iac_core #(
		.NUM_KEYS   (NUM_KEYS),
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign out_valid = valid_s2;
	assign out_word  = res_s2;

endmodule

@@ rtl/iac_regs.sv @@
// APB configuration register file of the alarm controller.
// Depends on iac_pkg.
`timescale 1ns / 1ps

module iac_regs import iac_pkg::*; #(
	parameter int unsigned NUM_ZONES = 8,
	parameter int unsigned NUM_KEYS  = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	// zones beyond the eight input bits never count
	localparam int unsigned ZW = (NUM_ZONES < 8) ? NUM_ZONES : 8;

	logic [15:0]   armed_delay_q;
	logic [15:0]   siren_ticks_q;
	logic [15:0]   beep_on_q;
	logic [15:0]   beep_off_q;
	logic [ZW-1:0] zone_mask_q;
	logic          muted_q;
	logic [31:0]   key_a_q;
	logic [31:0]   key_b_q;
	logic [2:0]    reg_idx;
	logic          wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_delay_q <= RST_ARMED_DELAY;
			siren_ticks_q <= RST_SIREN_TICKS;
			beep_on_q     <= RST_BEEP_ON;
			beep_off_q    <= RST_BEEP_OFF;
			zone_mask_q   <= '0;
			muted_q       <= 1'b0;
			key_a_q       <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ARMED_DELAY: armed_delay_q <= pwdata[15:0];
				REG_SIREN_TICKS: siren_ticks_q <= pwdata[15:0];
				REG_BEEP_ON:     beep_on_q     <= pwdata[15:0];
				REG_BEEP_OFF:    beep_off_q    <= pwdata[15:0];
				REG_ZONE_MASK:   zone_mask_q   <= pwdata[ZW-1:0];
				REG_MUTED:       muted_q       <= pwdata[0];
				REG_KEY_A:       key_a_q       <= pwdata;
				default: ;
			endcase
		end
	end

	generate
		if (NUM_KEYS >= 2) begin : g_key_b
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					key_b_q <= '0;
				end else if (wr_en && reg_idx == REG_KEY_B) begin
					key_b_q <= pwdata;
				end
			end
		end else begin : g_no_key_b
			assign key_b_q = '0;
		end
	endgenerate

	always_comb begin
		case (reg_idx)
			REG_ARMED_DELAY: prdata = 32'(armed_delay_q);
			REG_SIREN_TICKS: prdata = 32'(siren_ticks_q);
			REG_BEEP_ON:     prdata = 32'(beep_on_q);
			REG_BEEP_OFF:    prdata = 32'(beep_off_q);
			REG_ZONE_MASK:   prdata = 32'(zone_mask_q);
			REG_MUTED:       prdata = 32'(muted_q);
			REG_KEY_A:       prdata = key_a_q;
			REG_KEY_B:       prdata = key_b_q;
			default:         prdata = '0;
		endcase
	end

	assign cfg.armed_delay_ticks = armed_delay_q;
	assign cfg.siren_ticks       = siren_ticks_q;
	assign cfg.beep_on_ticks     = beep_on_q;
	assign cfg.beep_off_ticks    = beep_off_q;
	assign cfg.zone_enable_mask  = 8'(zone_mask_q);
	assign cfg.siren_muted       = muted_q;
	assign cfg.key_a             = key_a_q;
	assign cfg.key_b             = key_b_q;

endmodule

@@ rtl/iac_core.sv @@
// Alarm state machine, tick timers and siren/beep drive; one tick per step.
// Depends on iac_pkg.
`timescale 1ns / 1ps

module iac_core import iac_pkg::*; #(
	parameter int unsigned NUM_KEYS   = 2,
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_word_t  item,
	input  cfg_t      cfg,
	output out_word_t res
);

	localparam int unsigned CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	mode_t                 mode_q, mode_d;
	logic                  arm_q, arm_d;
	logic                  sounding_q, sounding_d;
	logic                  drive_q, drive_d;
	logic                  gap_q, gap_d;
	logic                  running_q, running_d;
	logic [TIMER_BITS-1:0] delay_q, delay_d;
	logic [TIMER_BITS-1:0] siren_q, siren_d;
	logic [TIMER_BITS-1:0] beep_q, beep_d;

	logic        arm_now;
	logic        key_ok;
	logic        tripped;
	logic        cancel;
	logic        delay_done;
	logic        siren_done;
	logic        beep_done;
	logic [15:0] beep_len;

	function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic reached(input logic [TIMER_BITS-1:0] v, input logic [15:0] len);
		return CW'(v) >= CW'(len);
	endfunction

	assign arm_now = item.host_arm_write ? item.host_arm_value : arm_q;
	assign key_ok  = item.key_present &&
		(item.key_value == cfg.key_a || (NUM_KEYS >= 2 && item.key_value == cfg.key_b));
	assign tripped = |(item.zone_levels & cfg.zone_enable_mask);
	assign cancel  = key_ok || !arm_now;

	assign beep_len   = gap_q ? cfg.beep_off_ticks : cfg.beep_on_ticks;
	assign delay_done = reached(delay_q, cfg.armed_delay_ticks);
	assign siren_done = reached(siren_q, cfg.siren_ticks);
	assign beep_done  = reached(beep_q, beep_len);

	// next mode
	always_comb begin
		case (mode_q)
			MODE_EXIT: begin
				if (cancel)          mode_d = MODE_DISARMED;
				else if (delay_done) mode_d = MODE_ARMED;
				else                 mode_d = MODE_EXIT;
			end
			MODE_ARMED: begin
				mode_d = cancel ? MODE_DISARMED : MODE_ARMED;
			end
			default: begin
				mode_d = (key_ok || arm_now) ? MODE_EXIT : MODE_DISARMED;
			end
		endcase
	end

	// timers and drive
	always_comb begin
		arm_d      = arm_now;
		sounding_d = sounding_q;
		drive_d    = drive_q;
		gap_d      = gap_q;
		running_d  = running_q;
		delay_d    = delay_q;
		siren_d    = siren_q;
		beep_d     = beep_q;
		case (mode_q)
			MODE_EXIT: begin
				if (cancel) begin
					arm_d   = 1'b0;
					delay_d = '0;
					drive_d = 1'b0;
				end else if (delay_done) begin
					delay_d   = '0;
					gap_d     = 1'b0;
					running_d = 1'b0;
					beep_d    = '0;
					drive_d   = 1'b0;
				end else begin
					delay_d = sat_inc(delay_q);
					if (!running_q) begin
						running_d = 1'b1;
						beep_d    = '0;
						if (!gap_q) drive_d = 1'b1;
					end else if (beep_done) begin
						running_d = 1'b0;
						beep_d    = '0;
						if (!gap_q) drive_d = 1'b0;
						gap_d = !gap_q;
					end else begin
						beep_d = sat_inc(beep_q);
					end
				end
			end
			MODE_ARMED: begin
				if (cancel || (sounding_q && siren_done)) begin
					if (cancel) arm_d = 1'b0;
					if (sounding_q) begin
						sounding_d = 1'b0;
						siren_d    = '0;
						if (!cfg.siren_muted) drive_d = 1'b0;
					end
				end else if (!sounding_q && tripped) begin
					sounding_d = 1'b1;
					siren_d    = '0;
					if (!cfg.siren_muted) drive_d = 1'b1;
				end else if (sounding_q) begin
					siren_d = sat_inc(siren_q);
				end
			end
			default: begin
				if (key_ok || arm_now) begin
					arm_d     = 1'b1;
					delay_d   = '0;
					gap_d     = 1'b0;
					running_d = 1'b0;
					beep_d    = '0;
					drive_d   = 1'b0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_DISARMED;
			arm_q      <= 1'b0;
			sounding_q <= 1'b0;
			drive_q    <= 1'b0;
			gap_q      <= 1'b0;
			running_q  <= 1'b0;
			delay_q    <= '0;
			siren_q    <= '0;
			beep_q     <= '0;
		end else if (step) begin
			mode_q     <= mode_d;
			arm_q      <= arm_d;
			sounding_q <= sounding_d;
			drive_q    <= drive_d;
			gap_q      <= gap_d;
			running_q  <= running_d;
			delay_q    <= delay_d;
			siren_q    <= siren_d;
			beep_q     <= beep_d;
		end
	end

	assign res.alarm_state  = mode_d;
	assign res.siren_drive  = drive_d;
	assign res.siren_active = sounding_d;
	assign res.arm_flag_out = arm_d;
	assign res.key_result   = !item.key_present ? KEY_NONE : (key_ok ? KEY_VALID : KEY_INVALID);
	assign res.zone_tripped = tripped;

endmodule

@@ rtl/iac_checker.sv @@
// Port-level checks of the intrusion alarm controller, bound to the top level.
// Depends on iac_pkg and intrusion_alarm_controller_defines.svh.
`timescale 1ns / 1ps
`include "intrusion_alarm_controller_defines.svh"

module iac_checker import iac_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_word
);

	// stalled result word holds
	`IAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

	// siren period only runs while armed
	`IAC_ASSERT_NOW(a_siren_armed, out_valid && out_word.siren_active, out_word.alarm_state == MODE_ARMED)

	// arm flag is set exactly when not disarmed
	`IAC_ASSERT_NOW(a_arm_state, out_valid, out_word.arm_flag_out == (out_word.alarm_state != MODE_DISARMED))

	// a valid card always leaves the controller out of the armed state
	`IAC_ASSERT_NOW(a_key_not_armed, out_valid && out_word.key_result == KEY_VALID, out_word.alarm_state != MODE_ARMED)

endmodule

bind intrusion_alarm_controller iac_checker u_iac_checker (.*);

@@ sim/tb_intrusion_alarm_controller.sv @@
`timescale 1ns / 1ps
// Testbench of the intrusion alarm controller: directed and random tick words
// checked against a tick-level model of the arm/exit/siren state machine.
// Depends on iac_pkg and the rtl top level intrusion_alarm_controller.

import iac_pkg::*;

// Mirrors the register file and the alarm state, predicts one status word per tick
class alarm_tick_checker;
	cfg_t        regs;
	out_word_t   status_due[$];
	int unsigned fails;
	int unsigned words_seen;

	mode_t       mode;
	logic        arm_req;
	logic        sounding;
	logic        drive;
	logic        beep_gap;
	logic        beep_run;
	logic [15:0] exit_cnt;
	logic [15:0] siren_cnt;
	logic [15:0] beep_cnt;

	function new();
		regs = '0;
		regs.armed_delay_ticks = RST_ARMED_DELAY;
		regs.siren_ticks = RST_SIREN_TICKS;
		regs.beep_on_ticks = RST_BEEP_ON;
		regs.beep_off_ticks = RST_BEEP_OFF;
		mode = MODE_DISARMED;
		{arm_req, sounding, drive, beep_gap, beep_run} = '0;
		exit_cnt = '0;
		siren_cnt = '0;
		beep_cnt = '0;
		fails = 0;
		words_seen = 0;
	endfunction

	function void set_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			REG_ARMED_DELAY: regs.armed_delay_ticks = val[15:0];
			REG_SIREN_TICKS: regs.siren_ticks = val[15:0];
			REG_BEEP_ON:     regs.beep_on_ticks = val[15:0];
			REG_BEEP_OFF:    regs.beep_off_ticks = val[15:0];
			REG_ZONE_MASK:   regs.zone_enable_mask = val[7:0];
			REG_MUTED:       regs.siren_muted = val[0];
			REG_KEY_A:       regs.key_a = val;
			REG_KEY_B:       regs.key_b = val;
			default: ;
		endcase
	endfunction

	// tick counters stick at all ones
	function logic [15:0] bump(logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function void beep_restart();
		beep_gap = 1'b0;
		beep_run = 1'b0;
		beep_cnt = '0;
		drive = 1'b0;
	endfunction

	function void end_siren();
		if (sounding) begin
			sounding = 1'b0;
			if (!regs.siren_muted)
				drive = 1'b0;
			siren_cnt = '0;
		end
	endfunction

	function void take_tick(in_word_t w);
		out_word_t   want;
		logic        valid;
		logic        tripped;
		logic [15:0] len;
		valid = 1'b0;
		// host command lands before the tick
		if (w.host_arm_write)
			arm_req = w.host_arm_value;
		want.key_result = KEY_NONE;
		if (w.key_present) begin
			valid = (w.key_value == regs.key_a) || (w.key_value == regs.key_b);
			want.key_result = valid ? KEY_VALID : KEY_INVALID;
		end
		tripped = |(w.zone_levels & regs.zone_enable_mask);

		case (mode)
			MODE_EXIT: begin
				if (valid || !arm_req) begin
					// exit delay cancelled, drive forced low
					mode = MODE_DISARMED;
					arm_req = 1'b0;
					exit_cnt = '0;
					drive = 1'b0;
				end else if (exit_cnt >= regs.armed_delay_ticks) begin
					mode = MODE_ARMED;
					exit_cnt = '0;
					beep_restart();
				end else begin
					exit_cnt = bump(exit_cnt);
					len = beep_gap ? regs.beep_off_ticks : regs.beep_on_ticks;
					if (!beep_run) begin
						beep_run = 1'b1;
						beep_cnt = '0;
						if (!beep_gap)
							drive = 1'b1;
					end else if (beep_cnt >= len) begin
						beep_run = 1'b0;
						beep_cnt = '0;
						if (!beep_gap)
							drive = 1'b0;
						beep_gap = !beep_gap;
					end else begin
						beep_cnt = bump(beep_cnt);
					end
				end
			end
			MODE_ARMED: begin
				if (valid || !arm_req) begin
					mode = MODE_DISARMED;
					arm_req = 1'b0;
					end_siren();
				end else if (!sounding && tripped) begin
					sounding = 1'b1;
					if (!regs.siren_muted)
						drive = 1'b1;
					siren_cnt = '0;
				end else if (sounding) begin
					if (siren_cnt >= regs.siren_ticks)
						end_siren();
					else
						siren_cnt = bump(siren_cnt);
				end
			end
			default: begin
				mode = MODE_DISARMED;
				if (valid || arm_req) begin
					mode = MODE_EXIT;
					arm_req = 1'b1;
					exit_cnt = '0;
					beep_restart();
				end
			end
		endcase

		want.alarm_state = mode;
		want.siren_drive = drive;
		want.siren_active = sounding;
		want.arm_flag_out = arm_req;
		want.zone_tripped = tripped;
		status_due.push_back(want);
	endfunction

	function string show(out_word_t w);
		return $sformatf("state=%0d drive=%0b active=%0b arm=%0b key=%0d zone=%0b",
			w.alarm_state, w.siren_drive, w.siren_active, w.arm_flag_out,
			w.key_result, w.zone_tripped);
	endfunction

	function void check_status(out_word_t got);
		out_word_t want;
		words_seen++;
		if (status_due.size() == 0) begin
			fails++;
			if (fails <= 10)
				$display("status word %0d with nothing pending: %s", words_seen, show(got));
			return;
		end
		want = status_due.pop_front();
		if (got.alarm_state !== want.alarm_state || got.siren_drive !== want.siren_drive ||
		    got.siren_active !== want.siren_active || got.arm_flag_out !== want.arm_flag_out ||
		    got.key_result !== want.key_result || got.zone_tripped !== want.zone_tripped) begin
			fails++;
			if (fails <= 10)
				$display("status word %0d mismatch\n  expected %s\n  actual   %s",
					words_seen, show(want), show(got));
		end
	endfunction
endclass

module tb_intrusion_alarm_controller;

	localparam int HOLD_CYCLES = 64;   // long receiver hold-off, fills the pipeline
	localparam int STALL_LIMIT = 2000; // cycles with no word moving before giving up

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	in_word_t          in_word = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_word_t         out_word;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	alarm_tick_checker status_check = new();
	cfg_t              plan;              // register values currently loaded
	bit                steady = 1'b0;     // no idling on either side while set
	bit                hold_go = 1'b0;    // asks the receiver for one long hold-off
	int unsigned       stuck = 0;

	intrusion_alarm_controller dut (.*);

	always #4 clk = ~clk;

	// Receiver: takes status words, idles at random, serves hold-off requests.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				status_check.check_status(out_word);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_go) begin
				hold_go = 1'b0;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady || ($urandom_range(0, 99) >= 14);
			end
		end
	end

	// Watchdog: counts cycles in which no word moves on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck <= 0;
		end else if (stuck >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			stuck <= stuck + 1;
		end
	end

	function automatic in_word_t tick(logic present, logic [31:0] key, logic [7:0] zones,
			logic host_wr, logic host_val);
		in_word_t w;
		w.key_present = present;
		w.key_value = key;
		w.zone_levels = zones;
		w.host_arm_write = host_wr;
		w.host_arm_value = host_val;
		return w;
	endfunction

	// Offers one tick word; random idle cycles ahead of it unless steady.
	// Meant to be called just after the clock rises; returns once in_ready is seen high with the word on offer.
	task automatic send_tick(in_word_t w);
		while (!steady && $urandom_range(0, 99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		status_check.take_tick(w);
	endtask

	// Sender goes quiet until every pending status word has come back.
	task automatic drain_status();
		in_valid <= 1'b0;
		@(posedge clk);
		while (status_check.status_due.size() != 0)
			@(posedge clk);
	endtask

	// Setup cycle, then access cycle; back-to-back writes keep psel high.
	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		status_check.set_reg(idx, val);
	endtask

	// Only called with the block idle (after drain_status).
	task automatic load_plan(cfg_t p);
		plan = p;
		reg_write(REG_ARMED_DELAY, 32'(p.armed_delay_ticks));
		reg_write(REG_SIREN_TICKS, 32'(p.siren_ticks));
		reg_write(REG_BEEP_ON, 32'(p.beep_on_ticks));
		reg_write(REG_BEEP_OFF, 32'(p.beep_off_ticks));
		reg_write(REG_ZONE_MASK, 32'(p.zone_enable_mask));
		reg_write(REG_MUTED, 32'(p.siren_muted));
		reg_write(REG_KEY_A, p.key_a);
		reg_write(REG_KEY_B, p.key_b);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Short timers so that exit delay, arming and most siren periods complete; one plan in six has the longest siren
	function automatic cfg_t random_plan();
		cfg_t p;
		p.armed_delay_ticks = 16'($urandom_range(0, 10));
		p.siren_ticks = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(0, 25));
		p.beep_on_ticks = 16'($urandom_range(0, 4));
		p.beep_off_ticks = 16'($urandom_range(0, 4));
		p.zone_enable_mask = 8'($urandom);
		p.siren_muted = 1'($urandom_range(0, 1));
		p.key_a = $urandom;
		p.key_b = $urandom;
		return p;
	endfunction

	// Mostly arm sessions: arm (host or card), quiet ticks with sparse zone
	// activity, then a disarm or nothing. The rest is unconstrained noise.
	// pause_at / hold_at trigger the sender pause and the receiver hold-off.
	task automatic run_phase(int count, int pause_at, int hold_at);
		int          sent;
		int          quiet;
		int          span;
		logic [31:0] good_key;
		sent = 0;
		while (sent < count) begin
			if (hold_at >= 0 && sent >= hold_at) begin
				hold_go = 1'b1;
				hold_at = -1;
			end
			if (pause_at >= 0 && sent >= pause_at) begin
				drain_status();
				pause_at = -1;
			end
			good_key = $urandom_range(0, 1) ? plan.key_a : plan.key_b;
			if ($urandom_range(0, 99) < 75) begin
				if ($urandom_range(0, 1))
					send_tick(tick(1'b0, $urandom, 8'h00, 1'b1, 1'b1));
				else
					send_tick(tick(1'b1, good_key, 8'h00, 1'b0, 1'b0));
				span = plan.armed_delay_ticks + plan.siren_ticks + 6;
				if (span > 40)
					span = 40;
				quiet = $urandom_range(1, span);
				repeat (quiet)
					send_tick(tick($urandom_range(0, 99) < 8, $urandom,
						($urandom_range(0, 99) < 70) ? 8'h00 : 8'($urandom),
						$urandom_range(0, 99) < 5, 1'b1));
				case ($urandom_range(0, 9))
					0, 1, 2, 3: send_tick(tick(1'b1, good_key, 8'($urandom), 1'b0, 1'b0));
					4, 5, 6:    send_tick(tick(1'b0, $urandom, 8'($urandom), 1'b1, 1'b0));
					default: ;
				endcase
				sent += quiet + 2;
			end else begin
				send_tick(tick(1'($urandom_range(0, 1)),
					($urandom_range(0, 2) == 0) ? good_key : $urandom,
					8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		cfg_t p;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: an all-zero card matches both default keys,
		// no zone is enabled, exit delay is long.
		send_tick(tick(1'b0, 32'h0000_0000, 8'h00, 1'b0, 1'b0));
		send_tick(tick(1'b0, 32'h0000_0000, 8'hFF, 1'b0, 1'b0));
		send_tick(tick(1'b1, 32'h0000_0000, 8'h00, 1'b0, 1'b0)); // card starts exit delay
		send_tick(tick(1'b1, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0)); // unknown card
		send_tick(tick(1'b1, 32'h0000_0000, 8'hFF, 1'b0, 1'b0)); // card cancels exit delay
		send_tick(tick(1'b0, 32'hFFFF_FFFF, 8'h00, 1'b1, 1'b1)); // host arm
		send_tick(tick(1'b0, 32'h0000_0000, 8'h00, 1'b1, 1'b0)); // host disarm in exit delay
		send_tick(tick(1'b0, 32'h0000_0000, 8'h00, 1'b1, 1'b0));
		drain_status();

		// Tiny timers: walk the whole arm / trip / siren / disarm cycle,
		// zero-length beep, zones outside the mask.
		p = '{armed_delay_ticks: 16'd1, siren_ticks: 16'd2, beep_on_ticks: 16'd0,
			beep_off_ticks: 16'd1, zone_enable_mask: 8'h81, siren_muted: 1'b0,
			key_a: 32'hFFFF_FFFF, key_b: 32'h1234_5678};
		load_plan(p);
		send_tick(tick(1'b0, 32'h0000_0000, 8'h00, 1'b1, 1'b1));
		send_tick(tick(1'b0, 32'h0000_0000, 8'h00, 1'b0, 1'b0));
		send_tick(tick(1'b0, 32'h0000_0000, 8'h00, 1'b0, 1'b0));
		send_tick(tick(1'b0, 32'h0000_0000, 8'h7E, 1'b0, 1'b0)); // masked zones only
		send_tick(tick(1'b0, 32'h0000_0000, 8'h80, 1'b0, 1'b0)); // intrusion
		repeat (3) send_tick(tick(1'b0, 32'h0000_0000, 8'h00, 1'b0, 1'b0));
		send_tick(tick(1'b0, 32'h0000_0000, 8'h01, 1'b0, 1'b0)); // trips again
		send_tick(tick(1'b1, 32'h1234_5678, 8'h01, 1'b0, 1'b0)); // disarm while sounding
		send_tick(tick(1'b1, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0)); // arm by card
		send_tick(tick(1'b1, 32'h0000_0000, 8'h00, 1'b0, 1'b0));
		send_tick(tick(1'b0, 32'h0000_0000, 8'h00, 1'b0, 1'b0));
		send_tick(tick(1'b0, 32'h0000_0000, 8'hFF, 1'b1, 1'b1)); // re-arm, no effect on the mode; the zones start the siren
		send_tick(tick(1'b0, 32'h0000_0000, 8'h00, 1'b1, 1'b0)); // host disarm from armed
		drain_status();

		// No idling anywhere for a whole phase
		steady = 1'b1;
		p = '{armed_delay_ticks: 16'd3, siren_ticks: 16'd4, beep_on_ticks: 16'd1,
			beep_off_ticks: 16'd2, zone_enable_mask: 8'hFF, siren_muted: 1'b0,
			key_a: $urandom, key_b: $urandom};
		load_plan(p);
		run_phase(70, -1, -1);
		drain_status();
		steady = 1'b0;

		// All-zero timers, muted, extreme keys; receiver hold-off mid phase
		p = '{armed_delay_ticks: 16'd0, siren_ticks: 16'd0, beep_on_ticks: 16'd0,
			beep_off_ticks: 16'd0, zone_enable_mask: 8'hFF, siren_muted: 1'b1,
			key_a: 32'h0000_0000, key_b: 32'hFFFF_FFFF};
		load_plan(p);
		run_phase(70, -1, 20);
		drain_status();

		// Longest timers: the exit delay never runs out here
		p = '{armed_delay_ticks: 16'hFFFF, siren_ticks: 16'hFFFF, beep_on_ticks: 16'hFFFF,
			beep_off_ticks: 16'hFFFF, zone_enable_mask: 8'h00, siren_muted: 1'b0,
			key_a: $urandom, key_b: $urandom};
		load_plan(p);
		run_phase(30, -1, -1);
		drain_status();

		// Random short settings; the alarm state carries over between phases,
		// so mute can change while the siren sounds. One sender pause.
		for (int ph = 0; ph < 4; ph++) begin
			load_plan(random_plan());
			run_phase(70, (ph == 1) ? 35 : -1, -1);
			drain_status();
		end

		repeat (8) @(posedge clk);
		if (status_check.fails == 0 && status_check.status_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/iac_pkg.sv
rtl/iac_regs.sv
rtl/iac_core.sv
rtl/intrusion_alarm_controller.sv
rtl/iac_checker.sv
sim/tb_intrusion_alarm_controller.sv
